/* design/key_typematic_repeat_tracker_top_macros.svh */
// assertion macros for the typematic repeat tracker
`ifndef KEY_TYPEMATIC_REPEAT_TRACKER_TOP_MACROS_SVH
`define KEY_TYPEMATIC_REPEAT_TRACKER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define KTRT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ktrt same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define KTRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ktrt next-cycle check failed");
`else
`define KTRT_ASSERT_IMPL(lbl, ante, cons)
`define KTRT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/ktrt_pkg.sv */
// shared types, codes and constants of the typematic repeat tracker
package ktrt_pkg;

    // field widths
    localparam int KEY_W   = 9;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 16;
    localparam int DT_W    = 10;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // key codes at or above this are ignored
    localparam int KEY_LIMIT = 512;

    // repeat events per tick
    localparam int MAX_OUT = 16;
    localparam int NOUT_W  = 5;

    // request codes
    localparam logic [1:0] REQ_PRESS   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    // event codes
    localparam logic [1:0] EV_PRESSED  = 2'd0;
    localparam logic [1:0] EV_RELEASED = 2'd1;
    localparam logic [1:0] EV_REPEAT   = 2'd2;
    localparam logic [1:0] EV_DROPPED  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_DELAY  = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_CAPS   = 2'd2;

    // register reset values
    localparam logic [DUR_W-1:0] DELAY_RST  = 16'd500;
    localparam logic [DUR_W-1:0] PERIOD_RST = 16'd50;
    localparam logic [KEY_W-1:0] CAPS_RST   = 9'd280;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key_code;
        logic [DT_W-1:0]  elapsed_ms;
    } ktrt_in_t;

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [KEY_W-1:0] event_key;
        logic             caps_on;
        logic             last_event;
    } ktrt_out_t;

    typedef struct packed {
        logic [DUR_W-1:0] delay;
        logic [DUR_W-1:0] period;
        logic [KEY_W-1:0] caps_key;
    } ktrt_cfg_t;

    // one slot of the held-key table
    typedef struct packed {
        logic [KEY_W-1:0]  code;
        logic [TIME_W-1:0] hold_ms;
    } ktrt_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic idx_inc;
        logic scan_chk;
        logic tick_upd;
        logic dec_step;
        logic finish;
        logic flush;
    } ktrt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_noop;
        logic entry_valid;
        logic code_match;
        logic idx_last;
        logic old_above;
        logic div_busy;
        logic emit_wait;
        logic pend_valid;
        logic out_free;
    } ktrt_status_t;

endpackage

/* design/ktrt_ram.sv */
// generic single-write, single-read ram with registered read data
module ktrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ktrt_rem_div.sv */
// bit-serial remainder unit: one restoring step per cycle
module ktrt_rem_div import ktrt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] num,
    input  logic [DUR_W-1:0]  den,
    output logic              busy,
    output logic [DUR_W-1:0]  rem
);

    localparam int CNT_W = $clog2(TIME_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] num_reg, num_next;
    logic [DUR_W-1:0]  den_reg, den_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [DUR_W:0]    shifted;
    logic [DUR_W:0]    diff;

    // shift in the next numerator bit and trial subtract
    assign shifted = {rem_reg, num_reg[TIME_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TIME_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = (shifted >= {1'b0, den_reg}) ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
            num_next = {num_reg[TIME_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and partial remainder
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

/* design/ktrt_datapath.sv */
// held-key table, hold-time update, repeat test and result staging
module ktrt_datapath import ktrt_pkg::*; #(
    parameter int MAX_HELD = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  ktrt_in_t     in_data,
    input  ktrt_cfg_t    cfg,
    input  ktrt_cmd_t    cmd,
    output ktrt_status_t st,
    output logic         out_valid,
    input  logic         out_stall,
    output ktrt_out_t    out_data
);

    localparam int IDX_W   = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int ENTRY_W = $bits(ktrt_entry_t);

    // captured request
    logic [1:0]        req_type_reg, req_type_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DT_W-1:0]   dt_reg, dt_next;

    // table scan state
    logic              caps_reg, caps_next;
    logic [MAX_HELD-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic              free_found_reg, free_found_next;
    logic              match_reg, match_next;
    logic [NOUT_W-1:0] n_reg, n_next;

    // per-entry repeat test
    logic [KEY_W-1:0]  cur_code_reg, cur_code_next;
    logic [DT_W-1:0]   delta_reg, delta_next;
    logic              use_div_reg, use_div_next;
    logic              inc_direct_reg, inc_direct_next;

    // pending result and output register
    logic              pend_valid_reg, pend_valid_next;
    logic [1:0]        pend_kind_reg, pend_kind_next;
    logic [KEY_W-1:0]  pend_key_reg, pend_key_next;
    logic              out_valid_reg, out_valid_next;
    ktrt_out_t         out_data_reg, out_data_next;

    // table ram
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    ktrt_entry_t        ram_wentry;
    logic [ENTRY_W-1:0] ram_rdata;
    ktrt_entry_t        rd_entry;

    logic [DUR_W-1:0]  per_eff;
    logic [TIME_W-1:0] old_t;
    logic [TIME_W:0]   sum_t;
    logic [TIME_W-1:0] new_t;
    logic [TIME_W-1:0] step_t;
    logic              old_above;
    logic              inc_direct;
    logic [TIME_W-1:0] div_num;
    logic              div_start;
    logic              div_busy;
    logic [DUR_W-1:0]  div_rem;
    logic              inc_div;
    logic              want;
    logic              out_free;
    logic              is_press;
    logic              is_release;
    logic              is_tick;
    logic              key_ok;
    logic              caps_hit;
    logic              push_dec;
    logic              push_fin;

    ktrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_HELD)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    ktrt_rem_div u_rem_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (per_eff),
        .busy  (div_busy),
        .rem   (div_rem)
    );

    // request decode
    assign is_press   = (req_type_reg == REQ_PRESS);
    assign is_release = (req_type_reg == REQ_RELEASE);
    assign is_tick    = (req_type_reg == REQ_TICK);
    assign key_ok     = ({1'b0, key_reg} < (KEY_W + 1)'(KEY_LIMIT));
    assign caps_hit   = (in_data.req_type == REQ_PRESS)
                     && ({1'b0, in_data.key_code} < (KEY_W + 1)'(KEY_LIMIT))
                     && (in_data.key_code == cfg.caps_key);

    // hold-time update with saturation
    assign rd_entry  = ktrt_entry_t'(ram_rdata);
    assign per_eff   = (cfg.period == '0) ? DUR_W'(1) : cfg.period;
    assign old_t     = rd_entry.hold_ms;
    assign sum_t     = {1'b0, old_t} + (TIME_W + 1)'(dt_reg);
    assign new_t     = sum_t[TIME_W] ? '1 : sum_t[TIME_W-1:0];
    assign step_t    = new_t - old_t;
    assign old_above = (old_t > TIME_W'(cfg.delay));

    // below the delay: first repeat when new time reaches delay plus period
    assign inc_direct = ({1'b0, new_t}
                         >= ((TIME_W + 1)'(cfg.delay) + (TIME_W + 1)'(per_eff)));

    // past the delay: phase within the period plus the step crosses a boundary
    assign div_num   = old_t - TIME_W'(cfg.delay);
    assign div_start = cmd.tick_upd && old_above;
    assign inc_div   = (((DUR_W + 1)'(div_rem) + (DUR_W + 1)'(delta_reg))
                        >= (DUR_W + 1)'(per_eff));

    assign want     = (use_div_reg ? inc_div : inc_direct_reg)
                   && (n_reg < NOUT_W'(MAX_OUT));
    assign out_free = !out_valid_reg || !out_stall;
    assign push_dec = cmd.dec_step && want && pend_valid_reg;
    assign push_fin = cmd.flush && pend_valid_reg && out_free;

    // table write: hold-time update or new key
    always_comb
    begin
        if (cmd.tick_upd)
        begin
            ram_we     = 1'b1;
            ram_waddr  = idx_reg;
            ram_wentry = '{code: rd_entry.code, hold_ms: new_t};
        end
        else
        begin
            ram_we     = cmd.finish && is_press && !match_reg && free_found_reg;
            ram_waddr  = free_idx_reg;
            ram_wentry = '{code: key_reg, hold_ms: '0};
        end
    end

    // next-state logic
    always_comb
    begin
        req_type_next   = req_type_reg;
        key_next        = key_reg;
        dt_next         = dt_reg;
        caps_next       = caps_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        match_idx_next  = match_idx_reg;
        free_found_next = free_found_reg;
        match_next      = match_reg;
        n_next          = n_reg;
        cur_code_next   = cur_code_reg;
        delta_next      = delta_reg;
        use_div_next    = use_div_reg;
        inc_direct_next = inc_direct_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_key_next   = pend_key_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        // new request
        if (cmd.load_req)
        begin
            req_type_next   = in_data.req_type;
            key_next        = in_data.key_code;
            dt_next         = in_data.elapsed_ms;
            idx_next        = '0;
            free_found_next = 1'b0;
            match_next      = 1'b0;
            n_next          = '0;
            if (caps_hit)
            begin
                caps_next = !caps_reg;
            end
        end

        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        // key search and first free slot
        if (cmd.scan_chk)
        begin
            if (valid_reg[idx_reg] && (rd_entry.code == key_reg))
            begin
                match_next     = 1'b1;
                match_idx_next = idx_reg;
            end
            if (is_press && !valid_reg[idx_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx_reg;
            end
        end

        // capture the repeat test for this entry
        if (cmd.tick_upd)
        begin
            cur_code_next   = rd_entry.code;
            delta_next      = step_t[DT_W-1:0];
            use_div_next    = old_above;
            inc_direct_next = inc_direct;
        end

        // repeat event becomes the pending result
        if (cmd.dec_step && want)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = EV_REPEAT;
            pend_key_next   = cur_code_reg;
            n_next          = n_reg + NOUT_W'(1);
        end

        // press or release outcome
        if (cmd.finish)
        begin
            if (is_press && !match_reg)
            begin
                pend_valid_next = 1'b1;
                pend_key_next   = key_reg;
                if (free_found_reg)
                begin
                    pend_kind_next            = EV_PRESSED;
                    valid_next[free_idx_reg]  = 1'b1;
                end
                else
                begin
                    pend_kind_next = EV_DROPPED;
                end
            end
            if (is_release)
            begin
                pend_valid_next = 1'b1;
                pend_kind_next  = EV_RELEASED;
                pend_key_next   = key_reg;
                if (match_reg)
                begin
                    valid_next[match_idx_reg] = 1'b0;
                end
            end
        end

        if (push_fin)
        begin
            pend_valid_next = 1'b0;
        end

        // output register
        if (push_dec || push_fin)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '{event_kind: pend_kind_reg, event_key: pend_key_reg,
                               caps_on: caps_reg, last_event: push_fin};
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_type_reg   <= REQ_PRESS;
            caps_reg       <= 1'b0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            match_reg      <= 1'b0;
            n_reg          <= '0;
            use_div_reg    <= 1'b0;
            inc_direct_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            req_type_reg   <= req_type_next;
            caps_reg       <= caps_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            match_reg      <= match_next;
            n_reg          <= n_next;
            use_div_reg    <= use_div_next;
            inc_direct_reg <= inc_direct_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        dt_reg        <= dt_next;
        free_idx_reg  <= free_idx_next;
        match_idx_reg <= match_idx_next;
        cur_code_reg  <= cur_code_next;
        delta_reg     <= delta_next;
        pend_kind_reg <= pend_kind_next;
        pend_key_reg  <= pend_key_next;
        out_data_reg  <= out_data_next;
    end

    // status to the controller
    always_comb
    begin
        st.is_tick     = is_tick;
        st.is_noop     = !is_tick && !((is_press || is_release) && key_ok);
        st.entry_valid = valid_reg[idx_reg];
        st.code_match  = (rd_entry.code == key_reg);
        st.idx_last    = (idx_reg == IDX_W'(MAX_HELD - 1));
        st.old_above   = old_above;
        st.div_busy    = div_busy;
        st.emit_wait   = want && pend_valid_reg && !out_free;
        st.pend_valid  = pend_valid_reg;
        st.out_free    = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/ktrt_ctrl.sv */
// sequencer for table scans, tick updates and result flushing
module ktrt_ctrl import ktrt_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  ktrt_status_t st,
    output ktrt_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CHK   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_DEC   = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_FLUSH = 7'b1000000
    } ktrt_state_t;

    ktrt_state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                state_next = st.is_noop ? S_IDLE : S_CHK;
            end
            S_CHK:
            begin
                if (st.is_tick)
                begin
                    if (st.entry_valid)
                    begin
                        cmd.tick_upd = 1'b1;
                        state_next   = st.old_above ? S_DIV : S_DEC;
                    end
                    else if (st.idx_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
                else
                begin
                    cmd.scan_chk = 1'b1;
                    if ((st.entry_valid && st.code_match) || st.idx_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            S_DIV:
            begin
                if (!st.div_busy)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!st.emit_wait)
                begin
                    cmd.dec_step = 1'b1;
                    if (st.idx_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!(st.pend_valid && !st.out_free))
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

/* design/key_typematic_repeat_tracker_top.sv */
// top level of the typematic repeat tracker: register port, controller, datapath
//
// Requests enter on in_valid/in_stall/in_data: press, release or time tick.
// Events leave on out_valid/out_stall/out_data, one request giving zero or
// more events; the last event of a request carries last_event.
// Settings (repeat delay, repeat period, caps key) sit behind an APB-style
// port at byte addresses 0, 4 and 8; the user must write them while the block
// is idle, which the block itself does not enforce. One request is worked at
// a time; in_stall is high until it is finished. Press or release: the table
// is searched slot by slot, each slot read (S_RD) then checked (S_CHK), until
// the key is found or the last slot is checked; S_FIN and S_FLUSH follow.
// Tick: each slot is read and checked; a held key is tested in S_DEC, a key
// already repeating first waiting in S_DIV on the 32-step remainder unit.
// Events pass through a one-deep staging register and an output register;
// a stalled receiver holds out_data and the block waits before each push.
// Reset empties the table, clears caps lock and loads the default settings;
// no clearing pass is needed.
`include "key_typematic_repeat_tracker_top_macros.svh"

module key_typematic_repeat_tracker_top import ktrt_pkg::*; #(
    parameter int MAX_HELD = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ktrt_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ktrt_out_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [DUR_W-1:0] delay_reg, delay_next;
    logic [DUR_W-1:0] period_reg, period_next;
    logic [KEY_W-1:0] caps_key_reg, caps_key_next;
    logic             cfg_write;
    ktrt_cfg_t        cfg;
    ktrt_cmd_t        dp_cmd;
    ktrt_status_t     dp_st;

    // register writes
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        delay_next    = delay_reg;
        period_next   = period_reg;
        caps_key_next = caps_key_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_DELAY:  delay_next    = pwdata[DUR_W-1:0];
                REG_PERIOD: period_next   = pwdata[DUR_W-1:0];
                REG_CAPS:   caps_key_next = pwdata[KEY_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RST;
            period_reg   <= PERIOD_RST;
            caps_key_reg <= CAPS_RST;
        end
        else
        begin
            delay_reg    <= delay_next;
            period_reg   <= period_next;
            caps_key_reg <= caps_key_next;
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[3:2])
            REG_DELAY:  prdata = APB_DW'(delay_reg);
            REG_PERIOD: prdata = APB_DW'(period_reg);
            REG_CAPS:   prdata = APB_DW'(caps_key_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg = '{delay: delay_reg, period: period_reg, caps_key: caps_key_reg};

    ktrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (dp_st),
        .cmd      (dp_cmd)
    );

    ktrt_datapath #(
        .MAX_HELD (MAX_HELD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg       (cfg),
        .cmd       (dp_cmd),
        .st        (dp_st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a taken request keeps the input side busy in the next cycle
    `KTRT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // no staged event is left behind when a new request can enter
    `KTRT_ASSERT_IMPL(a_idle_nothing_staged, !in_stall, !dp_st.pend_valid)
    // a repeating key always starts the remainder unit
    `KTRT_ASSERT_NEXT(a_div_started, dp_cmd.tick_upd && dp_st.old_above, dp_st.div_busy)

endmodule

/* test/tb.sv */
// testbench for the typematic repeat tracker: random and directed requests, event checking
`timescale 1ns / 100ps

module tb;
    import ktrt_pkg::*;

    localparam int HELD_SLOTS = 16;
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // predicts the event stream of the tracker and holds the events still due
    class repeat_scoreboard;
        logic [DUR_W-1:0] delay_ms;
        logic [DUR_W-1:0] period_ms;
        logic [KEY_W-1:0] caps_key;
        logic caps;
        logic slot_busy[HELD_SLOTS];
        logic [KEY_W-1:0] slot_key[HELD_SLOTS];
        logic [TIME_W-1:0] slot_ms[HELD_SLOTS];
        ktrt_out_t events_due[$];
        int errors;

        function new();
            delay_ms = DELAY_RST;
            period_ms = PERIOD_RST;
            caps_key = CAPS_RST;
            caps = 1'b0;
            errors = 0;
            for (int i = 0; i < HELD_SLOTS; i++)
            begin
                slot_busy[i] = 1'b0;
                slot_key[i] = '0;
                slot_ms[i] = '0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_DELAY:  delay_ms = val[DUR_W-1:0];
                REG_PERIOD: period_ms = val[DUR_W-1:0];
                REG_CAPS:   caps_key = val[KEY_W-1:0];
                default: ;
            endcase
        endfunction

        // number of repeats reached after holding a key for hold ms
        function logic [TIME_W-1:0] repeats_at(logic [TIME_W-1:0] hold);
            logic [TIME_W-1:0] step;
            logic [TIME_W-1:0] dly;
            step = (period_ms == '0) ? 32'd1 : {16'd0, period_ms};
            dly = {16'd0, delay_ms};
            if (hold <= dly)
                return '0;
            return (hold - dly) / step;
        endfunction

        function int held_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < HELD_SLOTS; i++)
                if (slot_busy[i] && slot_key[i] == key)
                    return i;
            return -1;
        endfunction

        function ktrt_out_t event_of(logic [1:0] kind, logic [KEY_W-1:0] key);
            ktrt_out_t ev;
            ev.event_kind = kind;
            ev.event_key = key;
            ev.caps_on = caps;
            ev.last_event = 1'b0;
            return ev;
        endfunction

        // update the table for one accepted request and queue its events
        function void note_request(ktrt_in_t req);
            ktrt_out_t batch[$];
            int slot;
            logic [TIME_W-1:0] old_ms;
            logic [TIME_W-1:0] new_ms;
            logic [TIME_W-1:0] dt;
            dt = {22'd0, req.elapsed_ms};
            case (req.req_type)
                REQ_PRESS:
                begin
                    if (int'(req.key_code) < KEY_LIMIT)
                    begin
                        if (req.key_code == caps_key)
                            caps = !caps;
                        if (held_slot(req.key_code) < 0)
                        begin
                            slot = -1;
                            for (int i = HELD_SLOTS - 1; i >= 0; i--)
                                if (!slot_busy[i])
                                    slot = i;
                            if (slot >= 0)
                            begin
                                slot_busy[slot] = 1'b1;
                                slot_key[slot] = req.key_code;
                                slot_ms[slot] = '0;
                                batch.insert(batch.size(),
                                             event_of(EV_PRESSED, req.key_code));
                            end
                            else
                                batch.insert(batch.size(),
                                             event_of(EV_DROPPED, req.key_code));
                        end
                    end
                end
                REQ_RELEASE:
                begin
                    if (int'(req.key_code) < KEY_LIMIT)
                    begin
                        slot = held_slot(req.key_code);
                        if (slot >= 0)
                            slot_busy[slot] = 1'b0;
                        batch.insert(batch.size(), event_of(EV_RELEASED, req.key_code));
                    end
                end
                REQ_TICK:
                begin
                    for (int i = 0; i < HELD_SLOTS; i++)
                    begin
                        if (slot_busy[i])
                        begin
                            old_ms = slot_ms[i];
                            // hold time saturates instead of wrapping
                            new_ms = (old_ms > 32'hFFFF_FFFF - dt) ? 32'hFFFF_FFFF : old_ms + dt;
                            slot_ms[i] = new_ms;
                            if (repeats_at(new_ms) > repeats_at(old_ms)
                                    && batch.size() < MAX_OUT)
                                batch.insert(batch.size(), event_of(EV_REPEAT, slot_key[i]));
                        end
                    end
                end
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last_event = 1'b1;
            foreach (batch[i])
                events_due.insert(events_due.size(), batch[i]);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        // compare one delivered event with the oldest one due
        task check_event(ktrt_out_t got);
            ktrt_out_t want;
            if (events_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event kind %0d key %0d",
                                          got.event_kind, got.event_key));
                return;
            end
            want = events_due.pop_front();
            if (got.event_kind != want.event_kind)
                report_mismatch($sformatf("event_kind %0d, want %0d",
                                          got.event_kind, want.event_kind));
            if (got.event_key != want.event_key)
                report_mismatch($sformatf("event_key %0d, want %0d",
                                          got.event_key, want.event_key));
            if (got.caps_on !== want.caps_on)
                report_mismatch($sformatf("caps_on %0b, want %0b", got.caps_on, want.caps_on));
            if (got.last_event !== want.last_event)
                report_mismatch($sformatf("last_event %0b, want %0b",
                                          got.last_event, want.last_event));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    ktrt_in_t in_data;
    logic out_valid;
    logic out_stall;
    ktrt_out_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    repeat_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_hold;
    int cycle_count;
    logic [KEY_W-1:0] cur_caps;

    key_typematic_repeat_tracker_top #(.MAX_HELD(HELD_SLOTS)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall, with an optional long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_hold > 0)
            begin
                out_stall <= 1'b1;
                stall_hold = stall_hold - 1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // event monitor
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_event(out_data);

    function automatic ktrt_in_t request_of(logic [1:0] kind, logic [KEY_W-1:0] key,
                                            logic [DT_W-1:0] dt);
        ktrt_in_t r;
        r.req_type = kind;
        r.key_code = key;
        r.elapsed_ms = dt;
        return r;
    endfunction

    // mostly keys from a small pool so that presses and releases meet held keys
    function automatic ktrt_in_t random_request();
        ktrt_in_t r;
        int pick;
        int kp;
        pick = $urandom_range(99);
        kp = $urandom_range(99);
        if (kp < 10)
            r.key_code = cur_caps;
        else if (kp < 75)
            r.key_code = KEY_W'($urandom_range(18));
        else
            r.key_code = KEY_W'($urandom_range(511));
        r.elapsed_ms = ($urandom_range(3) == 0) ? DT_W'($urandom_range(1023))
                                                 : DT_W'($urandom_range(80));
        if (pick < 40)
            r.req_type = REQ_PRESS;
        else if (pick < 65)
            r.req_type = REQ_RELEASE;
        else if (pick < 96)
            r.req_type = REQ_TICK;
        else
            r.req_type = REQ_UNUSED;
        return r;
    endfunction

    // offer one request, with random gaps before it
    task automatic send_request(ktrt_in_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(r);
    endtask

    // register write followed by a read back
    task automatic write_reg(logic [1:0] idx, logic [31:0] val, logic [31:0] mask);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, val);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) != (val & mask))
            sb.report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                         idx, prdata & mask, val & mask));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // wait until all events are in and the block has finished any silent request
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one setting of the registers followed by random requests
    task automatic run_phase(logic [15:0] dly, logic [15:0] per, logic [8:0] ck, int items,
                             int hold_off);
        int sent;
        ktrt_in_t r;
        settle();
        write_reg(REG_DELAY, {16'd0, dly}, 32'h0000_FFFF);
        write_reg(REG_PERIOD, {16'd0, per}, 32'h0000_FFFF);
        write_reg(REG_CAPS, {23'd0, ck}, 32'h0000_01FF);
        cur_caps = ck;
        stall_hold = hold_off;
        sent = 0;
        while (sent < items)
        begin
            r = random_request();
            send_request(r);
            if (r.req_type != REQ_UNUSED)
                sent++;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 27;
        recv_idle_pct = 64;
        cur_caps = CAPS_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme keys, caps key pressed twice, stray release
        send_request(request_of(REQ_PRESS, 9'd0, 10'd0));
        send_request(request_of(REQ_PRESS, 9'd511, 10'd1023));
        send_request(request_of(REQ_PRESS, CAPS_RST, 10'd0));
        send_request(request_of(REQ_PRESS, CAPS_RST, 10'd0));
        send_request(request_of(REQ_RELEASE, CAPS_RST, 10'd0));
        send_request(request_of(REQ_RELEASE, 9'd300, 10'd0));
        // ticks: no time, past the delay, one period more
        send_request(request_of(REQ_TICK, 9'd0, 10'd0));
        send_request(request_of(REQ_TICK, 9'd511, 10'd1023));
        send_request(request_of(REQ_TICK, 9'd0, 10'd50));
        send_request(request_of(REQ_UNUSED, 9'd5, 10'd5));
        // fill the table, then overflow with a plain key and the caps key
        for (int k = 1; k <= 14; k++)
            send_request(request_of(REQ_PRESS, KEY_W'(k), 10'd0));
        send_request(request_of(REQ_PRESS, 9'd100, 10'd0));
        send_request(request_of(REQ_PRESS, CAPS_RST, 10'd0));
        // every slot repeats at once
        send_request(request_of(REQ_TICK, 9'd0, 10'd1023));

        // zero delay and zero period
        run_phase(16'd0, 16'd0, 9'd0, 70, 0);
        send_idle_pct = 64;
        recv_idle_pct = 27;
        run_phase(16'hFFFF, 16'hFFFF, 9'd511, 55, 0);
        run_phase(16'd37, 16'd1, 9'($urandom_range(18)), 65, 0);
        // no idling, with one long receiver hold-off at the start
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(16'($urandom_range(700, 200)), 16'($urandom_range(90, 10)), CAPS_RST, 70,
                  400);

        settle();
        if (sb.events_due.size() != 0)
            sb.report_mismatch($sformatf("%0d events never arrived", sb.events_due.size()));
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/ktrt_pkg.sv
design/ktrt_ram.sv
design/ktrt_rem_div.sv
design/ktrt_datapath.sv
design/ktrt_ctrl.sv
design/key_typematic_repeat_tracker_top.sv
test/tb.sv
